// File: rtl/lsc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsc_pkg
// Shared types and constants of the line sensor centroid block.
// ----------------------------------------------------------------------------
package lsc_pkg;

    localparam int LSC_SENSOR_COUNT = 16;

    localparam int RAW_W    = 12;
    localparam int IDX_IN_W = 4;
    localparam int WEIGHT_W = 17;
    localparam int MOMENT_W = 24;
    localparam int THR_W    = 16;
    localparam int POS_W    = 15;
    localparam int QUOT_W   = 32;
    localparam int STEP_W   = 6;

    localparam logic [RAW_W-1:0] FULL_SCALE    = 12'd4095;
    localparam logic [POS_W-1:0] EDGE_POS      = 15'd11520;
    localparam logic [THR_W-1:0] LOST_THR_INIT = 16'd500;

    typedef enum logic [1:0] {
        CMD_TRACK = 2'd0,
        CMD_WHITE = 2'd1,
        CMD_BLACK = 2'd2
    } t_cmd;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_SCALE,
        ST_LOAD,
        ST_MAC,
        ST_CHECK,
        ST_CENT,
        ST_DONE
    } t_state;

    // one request to the shared radix-2 divider
    typedef struct packed {
        logic [WEIGHT_W-1:0] rem_init;
        logic [QUOT_W-1:0]   dividend;
        logic [WEIGHT_W-1:0] divisor;
        logic [STEP_W-1:0]   steps;
    } t_div_req;

endpackage

// File: rtl/line_sensor_centroid_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_sensor_centroid_core
// Calibrates reflectance samples against per-sensor references and forms
// the weighted centroid of each frame.
// ----------------------------------------------------------------------------
// channel  direction  handshake                  payload
// in       input      i_in_valid / o_in_stall    cmd, sensor_index, sample_value,
//                                                frame_last
// out      output     o_out_valid / i_out_stall  calibrated_value, line_position,
//                                                position_valid, line_lost
// cfg      input      i_cfg_valid / o_cfg_ready  lost_threshold
//
// a reference write is taken without leaving idle; a track beat holds
// o_in_stall until it is done, running the rescale divide for the 12
// quotient bits, skipped when the sample clamps, and then the bit-serial
// multiply by the sensor position
// a frame-end beat adds the 32-bit centroid divide, one quotient bit per
// cycle in the shared divider, skipped when the line is lost
// synchronous active-low reset; references read as zero until written
// the output register holds a finished beat while the next input is taken
// ----------------------------------------------------------------------------
module line_sensor_centroid_core #(
    parameter int SENSOR_COUNT = lsc_pkg::LSC_SENSOR_COUNT
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [lsc_pkg::THR_W-1:0]           i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [1:0]                          i_cmd,
    input  logic [lsc_pkg::IDX_IN_W-1:0]        i_sensor_index,
    input  logic [lsc_pkg::RAW_W-1:0]           i_sample_value,
    input  logic                                i_frame_last,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [lsc_pkg::RAW_W-1:0]           o_calibrated_value,
    output logic signed [lsc_pkg::POS_W-1:0]    o_line_position,
    output logic                                o_position_valid,
    output logic                                o_line_lost
);
    import lsc_pkg::*;

    localparam int IDX_W = $clog2(SENSOR_COUNT);

    t_state r_state, n_state;

    logic [THR_W-1:0]    r_lost_thr;
    logic [IDX_IN_W-1:0] r_idx;
    logic [RAW_W-1:0]    r_raw;
    logic                r_last;
    logic [RAW_W-1:0]    r_cal;
    logic [WEIGHT_W-1:0] r_weight;
    logic [MOMENT_W-1:0] r_moment;
    logic [MOMENT_W-1:0] r_addend;
    logic [5:0]          r_pmag;
    logic                r_pneg;
    logic                r_mneg;
    logic                r_lost;
    logic                r_prev_neg;
    logic [POS_W-1:0]    r_pos;

    logic                accept_in;
    logic                in_range_in;
    logic                in_range;
    logic                ref_wr;
    logic [RAW_W-1:0]    ref_white;
    logic [RAW_W-1:0]    ref_black;
    logic                cal_zero;
    logic                cal_full;
    logic [RAW_W-1:0]    diff_raw;
    logic [RAW_W-1:0]    diff_ref;
    logic [2*RAW_W-1:0]  num_scaled;
    logic                frame_lost;
    logic [MOMENT_W-1:0] moment_mag;
    logic                div_start;
    t_div_req            div_req;
    logic                div_busy;
    logic                div_done;
    logic [QUOT_W-1:0]   div_quot;
    logic [POS_W-1:0]    cent_mag;
    logic                out_load;

    // |6*index - 45|
    function automatic logic [5:0] pos_mag(input logic [IDX_IN_W-1:0] idx);
        logic [6:0] six;
        six = ({3'b000, idx} << 2) + ({3'b000, idx} << 1);
        return idx[3] ? 6'(six - 7'd45) : 6'(7'd45 - six);
    endfunction

    assign accept_in   = i_in_valid && !o_in_stall;
    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign in_range_in = ({1'b0, i_sensor_index} < 5'(SENSOR_COUNT));
    assign in_range    = ({1'b0, r_idx} < 5'(SENSOR_COUNT));
    assign ref_wr      = accept_in && in_range_in &&
                         (i_cmd == CMD_WHITE || i_cmd == CMD_BLACK);

    lsc_ref_store #(
        .SENSOR_COUNT (SENSOR_COUNT),
        .IDX_W        (IDX_W)
    ) u_ref_store (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (ref_wr),
        .i_wr_black (i_cmd == CMD_BLACK),
        .i_addr     (i_sensor_index[IDX_W-1:0]),
        .i_wr_data  (i_sample_value),
        .i_rd_en    (accept_in),
        .o_white    (ref_white),
        .o_black    (ref_black)
    );

    // rescale decode, valid in the read state
    assign cal_zero   = !in_range || (ref_black <= ref_white) || (r_raw <= ref_white);
    assign cal_full   = (r_raw >= ref_black);
    assign diff_raw   = r_raw - ref_white;
    assign diff_ref   = ref_black - ref_white;
    assign num_scaled = {diff_raw, 12'd0} - {12'd0, diff_raw};

    assign frame_lost = (r_weight == '0) || (r_weight < {1'b0, r_lost_thr});
    assign moment_mag = r_moment[MOMENT_W-1] ? (~r_moment + 1'b1) : r_moment;

    lsc_serial_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_req   (div_req),
        .o_busy  (div_busy),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    assign cent_mag = (div_quot > QUOT_W'(EDGE_POS)) ? EDGE_POS : div_quot[POS_W-1:0];
    assign out_load = !o_out_valid || !i_out_stall;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept_in && i_cmd == CMD_TRACK) begin
                    n_state = ST_READ;
                end
            end
            ST_READ: begin
                n_state = (cal_zero || cal_full) ? ST_LOAD : ST_SCALE;
            end
            ST_SCALE: begin
                if (div_done) begin
                    n_state = ST_LOAD;
                end
            end
            ST_LOAD: begin
                n_state = ST_MAC;
            end
            ST_MAC: begin
                if (r_pmag == '0) begin
                    n_state = r_last ? ST_CHECK : ST_DONE;
                end
            end
            ST_CHECK: begin
                n_state = frame_lost ? ST_DONE : ST_CENT;
            end
            ST_CENT: begin
                if (div_done) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // divider requests
    always_comb begin
        div_start = 1'b0;
        div_req   = '0;
        case (r_state)
            ST_READ: begin
                // quotient stays below 4096, so the top half preloads the remainder
                div_start        = !cal_zero && !cal_full;
                div_req.rem_init = {5'd0, num_scaled[2*RAW_W-1:RAW_W]};
                div_req.dividend = {num_scaled[RAW_W-1:0], 20'd0};
                div_req.divisor  = {5'd0, diff_ref};
                div_req.steps    = STEP_W'(RAW_W);
            end
            ST_CHECK: begin
                div_start        = !frame_lost;
                div_req.rem_init = '0;
                div_req.dividend = {moment_mag, 8'd0};
                div_req.divisor  = r_weight;
                div_req.steps    = STEP_W'(QUOT_W);
            end
            default: begin
                div_start = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_lost_thr <= LOST_THR_INIT;
            r_weight   <= '0;
            r_moment   <= '0;
            r_prev_neg <= 1'b0;
            r_pmag     <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                r_lost_thr <= i_cfg_data;
            end
            case (r_state)
                ST_LOAD: begin
                    if (in_range) begin
                        r_weight <= r_weight + {5'd0, r_cal};
                        r_pmag   <= pos_mag(r_idx);
                    end else begin
                        r_pmag <= '0;
                    end
                end
                ST_MAC: begin
                    // one bit of the position magnitude per cycle
                    if (r_pmag != '0) begin
                        if (r_pmag[0]) begin
                            r_moment <= r_pneg ? r_moment - r_addend : r_moment + r_addend;
                        end
                        r_pmag <= {1'b0, r_pmag[5:1]};
                    end
                end
                ST_CHECK: begin
                    r_weight <= '0;
                    r_moment <= '0;
                end
                ST_CENT: begin
                    if (div_done) begin
                        r_prev_neg <= r_mneg && (cent_mag != '0);
                    end
                end
                default: begin
                    r_pmag <= r_pmag;
                end
            endcase
        end
    end

    // payload path
    always_ff @(posedge i_clk) begin
        if (accept_in) begin
            r_idx  <= i_sensor_index;
            r_raw  <= i_sample_value;
            r_last <= i_frame_last;
        end
        case (r_state)
            ST_READ: begin
                r_cal <= cal_zero ? '0 : FULL_SCALE;
            end
            ST_SCALE: begin
                if (div_done) begin
                    r_cal <= div_quot[RAW_W-1:0];
                end
            end
            ST_LOAD: begin
                r_addend <= {12'd0, r_cal};
                r_pneg   <= !r_idx[3];
            end
            ST_MAC: begin
                r_addend <= {r_addend[MOMENT_W-2:0], 1'b0};
            end
            ST_CHECK: begin
                r_lost <= frame_lost;
                r_mneg <= r_moment[MOMENT_W-1];
                r_pos  <= r_prev_neg ? (~EDGE_POS + 1'b1) : EDGE_POS;
            end
            ST_CENT: begin
                if (div_done) begin
                    r_pos <= r_mneg ? (~cent_mag + 1'b1) : cent_mag;
                end
            end
            default: begin
                r_cal <= r_cal;
            end
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (r_state == ST_DONE && out_load) begin
            o_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_DONE && out_load) begin
            o_calibrated_value <= r_cal;
            o_line_position    <= r_last ? signed'(r_pos) : '0;
            o_position_valid   <= r_last;
            o_line_lost        <= r_last && r_lost;
        end
    end

`ifndef SYNTH
    a_div_idle_on_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_start |-> !div_busy)
        else $error("divider started while busy");

    a_plain_beat_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_position_valid) |-> (o_line_position == '0 && !o_line_lost))
        else $error("position fields set on a beat without frame end");

    a_lost_needs_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_line_lost) |-> o_position_valid)
        else $error("line lost without frame end");

    a_pos_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_position_valid) |->
            (o_line_position <= signed'(EDGE_POS) && o_line_position >= -signed'(EDGE_POS)))
        else $error("line position beyond the bar edge");
`endif

endmodule

// File: rtl/lsc_ref_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsc_ref_store
// Per-sensor white and black reference memories with registered read.
// ----------------------------------------------------------------------------
module lsc_ref_store #(
    parameter int SENSOR_COUNT = 16,
    parameter int IDX_W        = $clog2(SENSOR_COUNT)
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_wr_en,
    input  logic                      i_wr_black,
    input  logic [IDX_W-1:0]          i_addr,
    input  logic [lsc_pkg::RAW_W-1:0] i_wr_data,
    input  logic                      i_rd_en,
    output logic [lsc_pkg::RAW_W-1:0] o_white,
    output logic [lsc_pkg::RAW_W-1:0] o_black
);
    import lsc_pkg::*;

    logic [RAW_W-1:0]        r_white_mem [SENSOR_COUNT];
    logic [RAW_W-1:0]        r_black_mem [SENSOR_COUNT];
    logic [SENSOR_COUNT-1:0] r_white_vld;
    logic [SENSOR_COUNT-1:0] r_black_vld;
    logic [RAW_W-1:0]        r_white_rd;
    logic [RAW_W-1:0]        r_black_rd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_white_vld <= '0;
            r_black_vld <= '0;
        end else if (i_wr_en) begin
            if (i_wr_black) begin
                r_black_vld[i_addr] <= 1'b1;
            end else begin
                r_white_vld[i_addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            if (i_wr_black) begin
                r_black_mem[i_addr] <= i_wr_data;
            end else begin
                r_white_mem[i_addr] <= i_wr_data;
            end
        end
    end

    // an entry never written reads as zero
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_white_rd <= r_white_vld[i_addr] ? r_white_mem[i_addr] : '0;
            r_black_rd <= r_black_vld[i_addr] ? r_black_mem[i_addr] : '0;
        end
    end

    assign o_white = r_white_rd;
    assign o_black = r_black_rd;

endmodule

// File: rtl/lsc_serial_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsc_serial_div
// Restoring radix-2 divider, one quotient bit per cycle, shared by the
// rescale and the centroid.
// ----------------------------------------------------------------------------
module lsc_serial_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  lsc_pkg::t_div_req          i_req,
    output logic                       o_busy,
    output logic                       o_done,
    output logic [lsc_pkg::QUOT_W-1:0] o_quot
);
    import lsc_pkg::*;

    logic [WEIGHT_W-1:0] r_rem;
    logic [WEIGHT_W-1:0] r_div;
    logic [QUOT_W-1:0]   r_dvd;
    logic [QUOT_W-1:0]   r_quot;
    logic [STEP_W-1:0]   r_cnt;
    logic                r_busy;
    logic                r_done;

    logic [WEIGHT_W:0]   rem_sh;
    logic [WEIGHT_W+1:0] diff;
    logic                ge;

    assign rem_sh = {r_rem, r_dvd[QUOT_W-1]};
    assign diff   = {1'b0, rem_sh} - {2'b00, r_div};
    assign ge     = ~diff[WEIGHT_W+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_req.steps;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == STEP_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= i_req.rem_init;
            r_div  <= i_req.divisor;
            r_dvd  <= i_req.dividend;
            r_quot <= '0;
        end else if (r_busy) begin
            // remainder stays below the divisor, so it fits back in WEIGHT_W
            r_rem  <= ge ? diff[WEIGHT_W-1:0] : rem_sh[WEIGHT_W-1:0];
            r_dvd  <= {r_dvd[QUOT_W-2:0], 1'b0};
            r_quot <= {r_quot[QUOT_W-2:0], ge};
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule
